/* src/sctu_pkg.sv */
`timescale 1ns / 1ps

package sctu_pkg;

   localparam int unsigned FRONT_STAGES = 8;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_REPLY = 1'b1;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_POLL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_POLL  = 2'd2;

   localparam logic [31:0] RETRY_RESET     = 32'd10000;
   localparam logic [31:0] INIT_POLL_RESET = 32'd60000;
   localparam logic [31:0] MAX_POLL_RESET  = 32'd3600000;

   localparam logic [31:0] NTP_UNIX_DELTA = 32'd2208988800;
   localparam logic [9:0]  MS_PER_SEC     = 10'd1000;

   // residues of 2^16, 2^32 and 2^48 modulo 1000
   localparam logic [9:0] MOD_2_16 = 10'd536;
   localparam logic [9:0] MOD_2_32 = 10'd296;
   localparam logic [9:0] MOD_2_48 = 10'd656;

   // ceil(2^37 / 1000), exact for dividends below 2^27
   localparam logic [27:0] RECIP_27 = 28'd137438954;
   // ceil(2^29 / 1000), exact for dividends below 2^19
   localparam logic [19:0] RECIP_19 = 20'd536871;
   // ceil(2^41 / 1000), exact for 32-bit dividends
   localparam logic [31:0] RECIP_32 = 32'd2199023256;
   // inverse of 125 modulo 2^32
   localparam logic [31:0] INV_125  = 32'd652835029;

   localparam logic [22:0] FRAC_PER_MS     = 23'd4294967;
   localparam logic [8:0]  FRAC_PER_MS_REM = 9'd296;

   typedef struct packed {
      logic        operation;
      logic [31:0] now_ms;
      logic        clock_is_set;
      logic [63:0] local_time_ms;
      logic [31:0] orig_sec;
      logic [31:0] orig_frac;
      logic [31:0] recv_sec;
      logic [31:0] recv_frac;
      logic [31:0] xmit_sec;
      logic [31:0] xmit_frac;
   } req_type;

   typedef struct packed {
      logic               send_request;
      logic [31:0]        request_xmit_sec;
      logic [31:0]        request_xmit_frac;
      logic               set_clock;
      logic [31:0]        clock_value;
      logic signed [31:0] offset_ms;
      logic [8:0]         slew_wait_ms;
   } rsp_type;

   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   typedef struct packed {
      logic        op;
      logic [31:0] now;
      logic        clk_set;
      logic [63:0] local_ms;
      logic [26:0] rsum;
      logic [17:0] rq;
      logic [9:0]  ms;
      logic [31:0] qlo;
      logic [31:0] m1;
      logic [18:0] t296;
      logic [8:0]  q2;
      logic [31:0] xsec;
      logic [31:0] xfrac;
      logic [31:0] u1;
      logic [31:0] u2;
      logic [31:0] u3;
      logic [9:0]  f1;
      logic [9:0]  f2;
      logic [9:0]  f3;
      logic [41:0] t1;
      logic [41:0] t2;
      logic [41:0] t3;
      logic [63:0] d21;
      logic [63:0] d3;
      logic [63:0] sum;
      logic [31:0] ofs;
      logic [31:0] omag;
      logic [22:0] rq2;
      logic [9:0]  rmag;
   } front_word_type;

   typedef struct packed {
      logic        op;
      logic [31:0] now;
      logic        clk_set;
      logic [31:0] xsec;
      logic [31:0] xfrac;
      logic [31:0] ofs;
      logic [31:0] sec_base;
      logic [9:0]  rmag;
   } back_word_type;

endpackage

/* src/sctu_chan_if.sv */
`timescale 1ns / 1ps

interface sctu_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* src/sctu_front.sv */
`timescale 1ns / 1ps

module sctu_front (
   input  logic                    clock,
   input  logic                    reset,
   sctu_chan_if.sink               req,
   input  logic                    fifo_full,
   output logic                    push,
   output sctu_pkg::back_word_type push_word
);

   localparam int unsigned N = sctu_pkg::FRONT_STAGES;

   logic [N-1:0]             valid_ff;
   logic [N-1:0]             valid_in;
   sctu_pkg::front_word_type word_ff [N];
   sctu_pkg::front_word_type word_in [N];
   logic                     advance;

   function automatic logic [31:0] unix_sec(input logic [31:0] sec);
      return (sec != 32'd0) ? (sec - sctu_pkg::NTP_UNIX_DELTA) : 32'd0;
   endfunction

   function automatic logic [9:0] frac_ms(input logic [31:0] frac);
      logic [41:0] prod;
      prod = 42'(frac) * 42'(sctu_pkg::MS_PER_SEC);
      return prod[41:32];
   endfunction

   assign advance   = !fifo_full;
   assign req.ready = advance;
   assign valid_in  = {valid_ff[N-2:0], req.valid};

   always_comb begin
      logic [54:0] prod55;
      logic [38:0] prod39;
      logic [63:0] prod64;
      logic [63:0] diffl;

      // classify and split: local time residue, reply timestamps to seconds and ms
      word_in[0]               = '0;
      word_in[0].op            = req.payload.operation;
      word_in[0].now           = req.payload.now_ms;
      word_in[0].clk_set       = req.payload.clock_is_set;
      word_in[0].local_ms      = req.payload.local_time_ms;
      word_in[0].rsum          = 27'(req.payload.local_time_ms[15:0])
                               + 27'(req.payload.local_time_ms[31:16]) * 27'(sctu_pkg::MOD_2_16)
                               + 27'(req.payload.local_time_ms[47:32]) * 27'(sctu_pkg::MOD_2_32)
                               + 27'(req.payload.local_time_ms[63:48]) * 27'(sctu_pkg::MOD_2_48);
      word_in[0].u1            = unix_sec(req.payload.orig_sec);
      word_in[0].u2            = unix_sec(req.payload.recv_sec);
      word_in[0].u3            = unix_sec(req.payload.xmit_sec);
      word_in[0].f1            = frac_ms(req.payload.orig_frac);
      word_in[0].f2            = frac_ms(req.payload.recv_frac);
      word_in[0].f3            = frac_ms(req.payload.xmit_frac);

      word_in[1]    = word_ff[0];
      prod55        = 55'(word_ff[0].rsum) * 55'(sctu_pkg::RECIP_27);
      word_in[1].rq = prod55[54:37];
      word_in[1].t1 = 42'(word_ff[0].u1) * 42'(sctu_pkg::MS_PER_SEC) + 42'(word_ff[0].f1);
      word_in[1].t2 = 42'(word_ff[0].u2) * 42'(sctu_pkg::MS_PER_SEC) + 42'(word_ff[0].f2);
      word_in[1].t3 = 42'(word_ff[0].u3) * 42'(sctu_pkg::MS_PER_SEC) + 42'(word_ff[0].f3);

      word_in[2]     = word_ff[1];
      word_in[2].ms  = 10'(word_ff[1].rsum - 27'(word_ff[1].rq) * 27'(sctu_pkg::MS_PER_SEC));
      word_in[2].d21 = 64'(word_ff[1].t2) - 64'(word_ff[1].t1);
      word_in[2].d3  = 64'(word_ff[1].t3) - word_ff[1].local_ms;

      // exact division by 1000 modulo 2^32: drop three low bits, then times 1/125
      word_in[3]      = word_ff[2];
      diffl           = word_ff[2].local_ms - 64'(word_ff[2].ms);
      word_in[3].qlo  = diffl[34:3] * sctu_pkg::INV_125;
      word_in[3].m1   = 32'(word_ff[2].ms) * 32'(sctu_pkg::FRAC_PER_MS);
      word_in[3].t296 = 19'(word_ff[2].ms) * 19'(sctu_pkg::FRAC_PER_MS_REM);
      word_in[3].sum  = word_ff[2].d21 + word_ff[2].d3;

      // halve toward zero
      word_in[4]      = word_ff[3];
      word_in[4].xsec = word_ff[3].qlo + sctu_pkg::NTP_UNIX_DELTA;
      prod39          = 39'(word_ff[3].t296) * 39'(sctu_pkg::RECIP_19);
      word_in[4].q2   = prod39[37:29];
      word_in[4].ofs  = word_ff[3].sum[32:1] + 32'(word_ff[3].sum[63] & word_ff[3].sum[0]);

      word_in[5]       = word_ff[4];
      word_in[5].xfrac = word_ff[4].m1 + 32'(word_ff[4].q2);
      word_in[5].omag  = word_ff[4].ofs[31] ? (~word_ff[4].ofs + 32'd1) : word_ff[4].ofs;

      word_in[6]     = word_ff[5];
      prod64         = 64'(word_ff[5].omag) * 64'(sctu_pkg::RECIP_32);
      word_in[6].rq2 = prod64[63:41];

      word_in[7]      = word_ff[6];
      word_in[7].rmag = 10'(word_ff[6].omag - 32'(word_ff[6].rq2) * 32'(sctu_pkg::MS_PER_SEC));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign push               = advance && valid_ff[N-1];
   assign push_word.op       = word_ff[N-1].op;
   assign push_word.now      = word_ff[N-1].now;
   assign push_word.clk_set  = word_ff[N-1].clk_set;
   assign push_word.xsec     = word_ff[N-1].xsec;
   assign push_word.xfrac    = word_ff[N-1].xfrac;
   assign push_word.ofs      = word_ff[N-1].ofs;
   assign push_word.sec_base = word_ff[N-1].u3;
   assign push_word.rmag     = word_ff[N-1].rmag;

endmodule

/* src/sctu_fifo.sv */
`timescale 1ns / 1ps

module sctu_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sctu_pkg::back_word_type push_word,
   output logic                    full,
   input  logic                    pop,
   output sctu_pkg::back_word_type pop_word,
   output logic                    not_empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   sctu_pkg::back_word_type mem_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff;
   logic [PTR_W-1:0]        wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff;
   logic [PTR_W-1:0]        rd_ptr_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_word  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count lost a word");
`endif

endmodule

/* src/sctu_back.sv */
`timescale 1ns / 1ps

module sctu_back (
   input  logic                    clock,
   input  logic                    reset,
   input  sctu_pkg::csr_write_type csr,
   input  logic                    fifo_valid,
   input  sctu_pkg::back_word_type fifo_word,
   output logic                    pop,
   sctu_chan_if.source             rsp
);

   logic [31:0]       retry_ff;
   logic [31:0]       retry_in;
   logic [31:0]       max_poll_ff;
   logic [31:0]       max_poll_in;
   logic [31:0]       poll_ff;
   logic [31:0]       poll_in;
   logic [31:0]       last_poll_ff;
   logic [31:0]       last_poll_in;
   logic [31:0]       slew_start_ff;
   logic [31:0]       slew_start_in;
   logic [31:0]       pend_sec_ff;
   logic [31:0]       pend_sec_in;
   logic [8:0]        pend_slew_ff;
   logic [8:0]        pend_slew_in;
   logic              reply_seen_ff;
   logic              reply_seen_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   sctu_pkg::rsp_type rsp_word_ff;
   sctu_pkg::rsp_type rsp_word_in;

   logic        is_tick;
   logic        send;
   logic        fire;
   logic        oneg;
   logic        round_up;
   logic [31:0] poll_el;
   logic [31:0] slew_el;
   logic [32:0] doubled;
   logic [31:0] capped;
   logic [9:0]  slew_full;
   logic [8:0]  slew;
   logic [31:0] round_sec;

   assign pop = fifo_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      is_tick = (fifo_word.op == sctu_pkg::OP_TICK);
      poll_el = fifo_word.now - last_poll_ff;
      send    = ((!reply_seen_ff || !fifo_word.clk_set) && (poll_el > retry_ff))
              || (fifo_word.clk_set && (poll_el > poll_ff));
      doubled = {poll_ff, 1'b0};
      capped  = (doubled > {1'b0, max_poll_ff}) ? max_poll_ff : doubled[31:0];
      slew_el = fifo_word.now - slew_start_ff;
      fire    = (pend_slew_ff != '0) && (slew_el > 32'(pend_slew_ff));

      // round the server seconds up when a positive offset leaves a remainder, and wait out half the gap
      oneg      = fifo_word.ofs[31];
      round_up  = !oneg && (fifo_word.rmag != '0);
      slew_full = round_up ? (sctu_pkg::MS_PER_SEC - fifo_word.rmag)
                           : (oneg ? fifo_word.rmag : 10'd0);
      slew      = slew_full[9:1];
      round_sec = round_up ? (fifo_word.sec_base + 32'd1) : fifo_word.sec_base;

      retry_in      = retry_ff;
      max_poll_in   = max_poll_ff;
      poll_in       = poll_ff;
      last_poll_in  = last_poll_ff;
      slew_start_in = slew_start_ff;
      pend_sec_in   = pend_sec_ff;
      pend_slew_in  = pend_slew_ff;
      reply_seen_in = reply_seen_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;

      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = '0;
         if (is_tick) begin
            if (send) begin
               last_poll_in  = fifo_word.now;
               reply_seen_in = 1'b0;
               if (fifo_word.clk_set && reply_seen_ff) begin
                  poll_in = capped;
               end
               rsp_word_in.send_request = 1'b1;
               if (fifo_word.clk_set) begin
                  rsp_word_in.request_xmit_sec  = fifo_word.xsec;
                  rsp_word_in.request_xmit_frac = fifo_word.xfrac;
               end
            end
            if (fire) begin
               rsp_word_in.set_clock   = 1'b1;
               rsp_word_in.clock_value = pend_sec_ff;
               pend_slew_in            = '0;
            end
         end else begin
            pend_slew_in             = slew;
            pend_sec_in              = round_sec;
            slew_start_in            = fifo_word.now;
            reply_seen_in            = 1'b1;
            rsp_word_in.offset_ms    = $signed(fifo_word.ofs);
            rsp_word_in.slew_wait_ms = slew;
         end
      end

      if (csr.we) begin
         case (csr.index)
            sctu_pkg::CSR_RETRY: begin
               retry_in = csr.data;
            end
            sctu_pkg::CSR_INIT_POLL: begin
               poll_in = csr.data;
            end
            sctu_pkg::CSR_MAX_POLL: begin
               max_poll_in = csr.data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff      <= sctu_pkg::RETRY_RESET;
         max_poll_ff   <= sctu_pkg::MAX_POLL_RESET;
         poll_ff       <= sctu_pkg::INIT_POLL_RESET;
         last_poll_ff  <= '0;
         slew_start_ff <= '0;
         pend_sec_ff   <= '0;
         pend_slew_ff  <= '0;
         reply_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         retry_ff      <= retry_in;
         max_poll_ff   <= max_poll_in;
         poll_ff       <= poll_in;
         last_poll_ff  <= last_poll_in;
         slew_start_ff <= slew_start_in;
         pend_sec_ff   <= pend_sec_in;
         pend_slew_ff  <= pend_slew_in;
         reply_seen_ff <= reply_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_word_ff;

`ifndef NO_ASSERTIONS
   a_reply_word: assert property (@(posedge clock) disable iff (reset)
      pop && (fifo_word.op == sctu_pkg::OP_REPLY) |=>
         !rsp_word_ff.send_request && !rsp_word_ff.set_clock
         && (rsp_word_ff.slew_wait_ms < 9'd500))
      else $error("reply word carries tick fields or slew out of range");

   a_poll_cap: assert property (@(posedge clock) disable iff (reset)
      pop && is_tick && send && fifo_word.clk_set && reply_seen_ff && !csr.we |=>
         poll_ff <= max_poll_ff)
      else $error("poll interval above cap after doubling");
`endif

endmodule

/* src/sntp_client_timing_unit.sv */
`timescale 1ns / 1ps
// channel    direction  payload                     handshake
// req_chan   in         sctu_pkg::req_type          valid/ready
// rsp_chan   out        sctu_pkg::rsp_type          valid/ready
// csr_*      in         index 0..2, 32-bit data     csr_we, no wait
//
// One word accepted and one word returned per cycle while rsp_chan is ready.
// The accept edge loads the first of eight front pipeline stages; the word then
// passes through the queue and the output register in the back part, which
// updates all state and raises rsp_chan.valid.
// Reset is synchronous; it empties the pipeline and the queue and loads the
// register defaults. A stalled response fills the QUEUE_DEPTH-entry queue,
// after which the front pipeline freezes and req_chan.ready drops.

module sntp_client_timing_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   sctu_chan_if.sink                            req_chan,
   sctu_chan_if.source                          rsp_chan,
   input  logic                                 csr_we,
   input  logic [sctu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sctu_pkg::CSR_DATA_W-1:0]      csr_data
);

   sctu_pkg::csr_write_type csr;
   sctu_pkg::back_word_type push_word;
   sctu_pkg::back_word_type pop_word;
   logic                    push;
   logic                    pop;
   logic                    fifo_full;
   logic                    fifo_valid;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   sctu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .fifo_full (fifo_full),
      .push      (push),
      .push_word (push_word)
   );

   sctu_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (fifo_full),
      .pop       (pop),
      .pop_word  (pop_word),
      .not_empty (fifo_valid)
   );

   sctu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .fifo_valid (fifo_valid),
      .fifo_word  (pop_word),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam logic [sctu_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_OFF_LEN = 300;
   localparam int PHASE_WORDS = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [sctu_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sctu_pkg::CSR_DATA_W-1:0] csr_data;

   sctu_chan_if #(.payload_type(sctu_pkg::req_type)) req_chan ();
   sctu_chan_if #(.payload_type(sctu_pkg::rsp_type)) rsp_chan ();

   sntp_client_timing_unit uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // client state mirror
   logic [31:0] retry_ms = sctu_pkg::RETRY_RESET;
   logic [31:0] max_poll_ms = sctu_pkg::MAX_POLL_RESET;
   logic [31:0] poll_ms = sctu_pkg::INIT_POLL_RESET;
   logic [31:0] last_send_ms = '0;
   logic got_reply = 1'b0;
   logic [8:0] slew_left = '0;
   logic [31:0] slew_from_ms = '0;
   logic [31:0] held_seconds = '0;

   // stimulus world
   logic [31:0] clock_ms = '0;
   logic [63:0] unix_ms = 64'd1_700_000_000_000;

   sctu_pkg::rsp_type timing_due[$];
   int mismatch_count = 0;
   int tick_count = 0;
   int reply_count = 0;
   int send_count = 0;
   int load_count = 0;
   int setting_count = 1;
   int quiet_cycles = 0;
   int hold_off_cycles = 0;
   logic send_gaps_on = 1'b1;
   logic recv_stalls_on = 1'b1;

   function automatic logic [31:0] ntp_to_unix(logic [31:0] s);
      return (s != 32'd0) ? s - sctu_pkg::NTP_UNIX_DELTA : 32'd0;
   endfunction

   function automatic logic [63:0] stamp_to_ms(logic [31:0] s, logic [31:0] f);
      logic [63:0] prod;
      prod = {32'd0, f} * 64'd1000;
      return {32'd0, ntp_to_unix(s)} * 64'd1000 + (prod >> 32);
   endfunction

   function automatic sctu_pkg::rsp_type advance_client(sctu_pkg::req_type w);
      sctu_pkg::rsp_type r;
      logic [31:0] since_send, since_reply, ms_part, ofs, omag, rem, secs, slew_ms;
      logic [32:0] doubled;
      logic [63:0] sum, mag, half;
      logic send;
      r = '0;
      if (w.operation == sctu_pkg::OP_TICK) begin
         tick_count++;
         since_send = w.now_ms - last_send_ms;
         send = ((!got_reply || !w.clock_is_set) && since_send > retry_ms) ||
                (w.clock_is_set && since_send > poll_ms);
         if (send) begin
            send_count++;
            last_send_ms = w.now_ms;
            if (w.clock_is_set && got_reply) begin
               doubled = {poll_ms, 1'b0};
               poll_ms = (doubled > {1'b0, max_poll_ms}) ? max_poll_ms : doubled[31:0];
            end
            got_reply = 1'b0;
            r.send_request = 1'b1;
            if (w.clock_is_set) begin
               ms_part = 32'(w.local_time_ms % 64'd1000);
               r.request_xmit_sec = 32'(w.local_time_ms / 64'd1000)
                                  + sctu_pkg::NTP_UNIX_DELTA;
               r.request_xmit_frac = ms_part * 32'd4294967 + (32'd296 * ms_part) / 32'd1000;
            end
         end
         since_reply = w.now_ms - slew_from_ms;
         if (slew_left != 9'd0 && since_reply > {23'd0, slew_left}) begin
            load_count++;
            r.set_clock = 1'b1;
            r.clock_value = held_seconds;
            slew_left = '0;
         end
      end else begin
         reply_count++;
         sum = (stamp_to_ms(w.recv_sec, w.recv_frac) - stamp_to_ms(w.orig_sec, w.orig_frac)) +
               (stamp_to_ms(w.xmit_sec, w.xmit_frac) - w.local_time_ms);
         mag = sum[63] ? 64'd0 - sum : sum;
         half = mag >> 1;
         ofs = sum[63] ? 32'(64'd0 - half) : half[31:0];
         omag = ofs[31] ? 32'd0 - ofs : ofs;
         rem = omag % 32'd1000;
         secs = ntp_to_unix(w.xmit_sec);
         if (!ofs[31] && rem != 32'd0) begin
            slew_ms = (32'd1000 - rem) / 32'd2;
            secs = secs + 32'd1;
         end else begin
            slew_ms = ofs[31] ? rem / 32'd2 : 32'd0;
         end
         slew_left = slew_ms[8:0];
         held_seconds = secs;
         slew_from_ms = w.now_ms;
         got_reply = 1'b1;
         r.offset_ms = ofs;
         r.slew_wait_ms = slew_ms[8:0];
      end
      return r;
   endfunction

   function automatic logic [63:0] unix_ms_to_ntp(logic [63:0] ms, logic [31:0] jitter);
      logic [63:0] frac;
      frac = (((ms % 64'd1000) << 32) + 64'd999) / 64'd1000 + {32'd0, jitter};
      return {32'(ms / 64'd1000) + sctu_pkg::NTP_UNIX_DELTA, frac[31:0]};
   endfunction

   function automatic sctu_pkg::req_type tick_word(logic [31:0] now, logic set,
                                                   logic [63:0] local_ms);
      sctu_pkg::req_type w;
      w = '0;
      w.operation = sctu_pkg::OP_TICK;
      w.now_ms = now;
      w.clock_is_set = set;
      w.local_time_ms = local_ms;
      return w;
   endfunction

   function automatic sctu_pkg::req_type reply_word(logic [31:0] now, logic set,
                                                    logic [63:0] local_ms, logic [63:0] t1,
                                                    logic [63:0] t2, logic [63:0] t3);
      sctu_pkg::req_type w;
      w = tick_word(now, set, local_ms);
      w.operation = sctu_pkg::OP_REPLY;
      {w.orig_sec, w.orig_frac} = t1;
      {w.recv_sec, w.recv_frac} = t2;
      {w.xmit_sec, w.xmit_frac} = t3;
      return w;
   endfunction

   function automatic sctu_pkg::req_type random_word();
      sctu_pkg::req_type w;
      longint off;
      logic [63:0] t1, t2, t3;
      int unsigned rtt, jmax;
      logic set;
      w = '0;
      if ($urandom_range(0, 7) == 0) begin
         w.operation = $urandom_range(0, 1) ? sctu_pkg::OP_REPLY : sctu_pkg::OP_TICK;
         w.now_ms = $urandom;
         w.clock_is_set = 1'($urandom_range(0, 1));
         w.local_time_ms = {$urandom, $urandom};
         w.orig_sec = $urandom;
         w.orig_frac = $urandom;
         w.recv_sec = $urandom;
         w.recv_frac = $urandom;
         w.xmit_sec = $urandom;
         w.xmit_frac = $urandom;
         return w;
      end
      set = ($urandom_range(0, 5) != 0);
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 9))
            5: clock_ms = last_send_ms + retry_ms + $urandom_range(0, 1);
            6: clock_ms = last_send_ms + poll_ms + $urandom_range(0, 1);
            7: clock_ms = slew_from_ms + 32'(slew_left) + $urandom_range(0, 1);
            8: clock_ms = clock_ms + $urandom_range(0, 100000);
            9: clock_ms = $urandom;
            default: clock_ms = clock_ms + $urandom_range(0, 700);
         endcase
         unix_ms = unix_ms + 64'($urandom_range(0, 700));
         return tick_word(clock_ms, set, unix_ms);
      end
      clock_ms = clock_ms + $urandom_range(0, 300);
      unix_ms = unix_ms + 64'($urandom_range(0, 300));
      rtt = $urandom_range(0, 400);
      jmax = 4000000;
      case ($urandom_range(0, 4))
         0: off = longint'($urandom_range(0, 3000)) - 1500;
         1: begin
            off = 1000 * (longint'($urandom_range(0, 20)) - 10);
            rtt = 0;
            jmax = 0;
         end
         2: off = longint'(int'($urandom)) * 1000 + longint'($urandom_range(0, 999));
         3: off = 0;
         default: off = longint'($urandom_range(0, 200000)) - 100000;
      endcase
      t1 = unix_ms_to_ntp(unix_ms - 64'(rtt), $urandom_range(0, jmax));
      t2 = unix_ms_to_ntp(unix_ms + off - 64'(rtt / 2), $urandom_range(0, jmax));
      t3 = unix_ms_to_ntp(unix_ms + off - 64'(rtt / 2) + 64'(jmax != 0 ? 3 : 0),
                          $urandom_range(0, jmax));
      if ($urandom_range(0, 9) == 0) t1 = {32'd0, $urandom};
      return reply_word(clock_ms, set, unix_ms, t1, t2, t3);
   endfunction

   task automatic send_word(sctu_pkg::req_type w);
      int gap;
      gap = send_gaps_on ? $urandom_range(0, 11) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.payload <= w;
      do @(posedge clock); while (!req_chan.ready);
      timing_due.push_back(advance_client(w));
   endtask

   task automatic settle_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (timing_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [sctu_pkg::CSR_INDEX_W-1:0] idx,
                            logic [sctu_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         sctu_pkg::CSR_RETRY: retry_ms = value;
         sctu_pkg::CSR_INIT_POLL: poll_ms = value;
         sctu_pkg::CSR_MAX_POLL: max_poll_ms = value;
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 200)
         $display("mismatch %0d at %0t: %s got %h want %h", mismatch_count, $realtime, what,
                  got, want);
   endtask

   task automatic test_directed_cases();
      logic [63:0] base;
      base = 64'd1_700_000_000_123;
      send_word(tick_word(32'd0, 1'b0, 64'd0));
      send_word(tick_word(32'd10001, 1'b0, '1));
      send_word(tick_word(32'd20002, 1'b1, '1));
      send_word(reply_word(32'd20010, 1'b1, base, unix_ms_to_ntp(base, 0),
                           unix_ms_to_ntp(base + 1234, 0), unix_ms_to_ntp(base + 1234, 0)));
      send_word(tick_word(32'd20011, 1'b1, base));
      send_word(tick_word(32'd20393, 1'b1, base));
      send_word(tick_word(32'd20394, 1'b1, base));
      send_word(tick_word(32'd80003, 1'b1, base + 60000));
      send_word(reply_word(32'd80010, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0));
      send_word(tick_word(32'd90020, 1'b1, 64'd0));
      send_word(tick_word(32'd90020, 1'b0, 64'd0));
      send_word(reply_word('1, 1'b1, '1, '1, '1, '1));
      send_word(reply_word(32'hFFFF_FFF0, 1'b1, base, unix_ms_to_ntp(base, 0),
                           unix_ms_to_ntp(base - 2500, 0), unix_ms_to_ntp(base - 2500, 0)));
      send_word(tick_word(32'h0000_00F9, 1'b1, base));
      send_word(reply_word(32'd123, 1'b1, base, unix_ms_to_ntp(base, 0),
                           unix_ms_to_ntp(base + 7000, 0), unix_ms_to_ntp(base + 7000, 0)));
      send_word(reply_word(32'd200, 1'b1, base, {32'd0, 32'hFFFF_FFFF},
                           {32'hFFFF_FFFF, 32'd0}, {32'd1, 32'hFFFF_FFFF}));
      send_word(tick_word('1, 1'b1, 64'd0));
      settle_idle();
   endtask

   task automatic test_register_extremes();
      logic [63:0] base;
      logic [31:0] b;
      base = 64'd1_700_000_500_000;
      write_csr(sctu_pkg::CSR_RETRY, 32'd0);
      write_csr(sctu_pkg::CSR_INIT_POLL, 32'd1);
      write_csr(sctu_pkg::CSR_MAX_POLL, 32'd1);
      write_csr(CSR_SPARE, '1);
      b = last_send_ms;
      send_word(tick_word(b, 1'b0, base));
      send_word(tick_word(b + 1, 1'b0, base));
      send_word(reply_word(b + 2, 1'b1, base, unix_ms_to_ntp(base, 0),
                           unix_ms_to_ntp(base + 1, 0), unix_ms_to_ntp(base + 1, 0)));
      send_word(tick_word(b + 4, 1'b1, base));
      settle_idle();
      write_csr(sctu_pkg::CSR_RETRY, '1);
      write_csr(sctu_pkg::CSR_INIT_POLL, 32'hF000_0000);
      write_csr(sctu_pkg::CSR_MAX_POLL, '1);
      b = last_send_ms;
      send_word(reply_word(b, 1'b1, base, unix_ms_to_ntp(base, 0),
                           unix_ms_to_ntp(base + 40, 0), unix_ms_to_ntp(base + 41, 0)));
      send_word(tick_word(b + 32'hF000_0001, 1'b1, base));
      b = last_send_ms;
      send_word(reply_word(b, 1'b1, base, unix_ms_to_ntp(base, 0),
                           unix_ms_to_ntp(base - 40, 0), unix_ms_to_ntp(base - 39, 0)));
      send_word(tick_word(b + 32'hFFFF_FFFF, 1'b1, base));
      send_word(tick_word(b + 32'hFFFF_FFFF, 1'b0, base));
      settle_idle();
      setting_count += 2;
   endtask

   task automatic test_random_traffic();
      logic [31:0] retry_set[5];
      logic [31:0] init_set[5];
      logic [31:0] max_set[5];
      retry_set = '{sctu_pkg::RETRY_RESET, 32'd50, 32'd0, '1, 32'($urandom_range(0, 20000))};
      init_set = '{sctu_pkg::INIT_POLL_RESET, 32'd100, 32'd1, '1, $urandom | 32'd1};
      max_set = '{sctu_pkg::MAX_POLL_RESET, 32'd1600, '1, 32'd1, $urandom | 32'd1};
      for (int p = 0; p < 5; p++) begin
         write_csr(sctu_pkg::CSR_RETRY, retry_set[p]);
         write_csr(sctu_pkg::CSR_INIT_POLL, init_set[p]);
         write_csr(sctu_pkg::CSR_MAX_POLL, max_set[p]);
         if (p == 4) write_csr(CSR_SPARE, $urandom);
         setting_count++;
         repeat (PHASE_WORDS) send_word(random_word());
         settle_idle();
      end
   endtask

   task automatic test_back_pressure();
      send_gaps_on = 1'b0;
      hold_off_cycles = HOLD_OFF_LEN;
      repeat (40) send_word(random_word());
      send_gaps_on = 1'b1;
      settle_idle();
   endtask

   task automatic test_steady_stream();
      send_gaps_on = 1'b0;
      recv_stalls_on = 1'b0;
      repeat (30) send_word(random_word());
      settle_idle();
      send_gaps_on = 1'b1;
      recv_stalls_on = 1'b1;
   endtask

   initial begin : result_sink
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = recv_stalls_on ? $urandom_range(0, 11) : 0;
         end
         repeat (stall) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   always @(posedge clock) begin : check_results
      sctu_pkg::rsp_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (timing_due.size() == 0) begin
            report_mismatch("word with nothing due", 64'(got.clock_value), 64'd0);
         end else begin
            want = timing_due.pop_front();
            if (got.send_request !== want.send_request)
               report_mismatch("send_request", 64'(got.send_request), 64'(want.send_request));
            if (got.request_xmit_sec !== want.request_xmit_sec)
               report_mismatch("request_xmit_sec", 64'(got.request_xmit_sec),
                               64'(want.request_xmit_sec));
            if (got.request_xmit_frac !== want.request_xmit_frac)
               report_mismatch("request_xmit_frac", 64'(got.request_xmit_frac),
                               64'(want.request_xmit_frac));
            if (got.set_clock !== want.set_clock)
               report_mismatch("set_clock", 64'(got.set_clock), 64'(want.set_clock));
            if (got.clock_value !== want.clock_value)
               report_mismatch("clock_value", 64'(got.clock_value), 64'(want.clock_value));
            if (got.offset_ms !== want.offset_ms)
               report_mismatch("offset_ms", 64'(unsigned'(got.offset_ms)),
                               64'(unsigned'(want.offset_ms)));
            if (got.slew_wait_ms !== want.slew_wait_ms)
               report_mismatch("slew_wait_ms", 64'(got.slew_wait_ms), 64'(want.slew_wait_ms));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", quiet_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_register_extremes();
      test_random_traffic();
      test_back_pressure();
      test_steady_stream();
      settle_idle();
      repeat (sctu_pkg::FRONT_STAGES + 4) @(posedge clock);
      $display("checked %0d ticks (%0d requests, %0d clock loads) and %0d replies",
               tick_count, send_count, load_count, reply_count);
      $display("across %0d register settings, random gaps, a %0d-cycle output hold-off",
               setting_count, HOLD_OFF_LEN);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
